[rtl/positional_list_engine_macros.svh]
// ---------------------------------------------------------------------------
// Positional list engine assertion macros
// Shared wrappers for concurrent assertions clocked on clk_i.
// ---------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_MACROS_SVH
`define POSITIONAL_LIST_ENGINE_MACROS_SVH

// Assertion that is checked only while reset is released.
`define PLE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Assertion that is checked at every clock edge, reset included.
`define PLE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[rtl/pl_pkg.sv]
// ---------------------------------------------------------------------------
// Positional list engine package
// Sizes, command and status codes, and the control word of the cell chain.
// ---------------------------------------------------------------------------
package pl_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned ELEM_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = $clog2(CAPACITY + 1);

  // Fixed widths of the transfer fields.
  localparam int unsigned FUNC_W   = 3;
  localparam int unsigned POS_W    = 7;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FN_INS_FRONT = 3'd0,
    FN_INS_BACK  = 3'd1,
    FN_INS_POS   = 3'd2,
    FN_REM_FRONT = 3'd3,
    FN_REM_BACK  = 3'd4,
    FN_REM_POS   = 3'd5
  } func_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_FULL   = 2'd3
  } status_e;

  // Command word broadcast to every cell of the chain.
  typedef struct packed {
    logic              ins;
    logic              rem;
    logic [IDX_W-1:0]  at;
    logic [ELEM_W-1:0] value;
  } cell_ctl_t;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [POS_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } cmd_t;

endpackage

[rtl/pl_cmd_if.sv]
// ---------------------------------------------------------------------------
// Command channel
// Valid/ready channel that carries one list command per transfer.
// ---------------------------------------------------------------------------
interface pl_cmd_if import pl_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [FUNC_W-1:0]  func;
  logic [POS_W-1:0]   pos;
  logic [VALUE_W-1:0] value;

  modport source (output valid, output func, output pos, output value, input ready);
  modport sink (input valid, input func, input pos, input value, output ready);
endinterface

[rtl/pl_rsp_if.sv]
// ---------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one command result per transfer.
// ---------------------------------------------------------------------------
interface pl_rsp_if import pl_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VALUE_W-1:0]  removed_value;
  logic [STATUS_W-1:0] status;
  logic [CNT_W-1:0]    count;

  modport source (output valid, output removed_value, output status, output count,
                  input ready);
  modport sink (input valid, input removed_value, input status, input count,
                output ready);
endinterface

[rtl/pl_cell.sv]
// ---------------------------------------------------------------------------
// List cell
// Holds one element and shifts toward or away from its neighbors.
// ---------------------------------------------------------------------------
module pl_cell import pl_pkg::*; (
  input  logic              clk_i,
  input  logic [IDX_W-1:0]  idx_i,
  input  cell_ctl_t         ctl_i,
  input  logic [ELEM_W-1:0] left_i,
  input  logic [ELEM_W-1:0] right_i,
  output logic [ELEM_W-1:0] data_o,
  output logic [ELEM_W-1:0] taken_o
);

  logic [ELEM_W-1:0] data_q;
  logic [ELEM_W-1:0] taken_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.ins) begin
      if (idx_i > ctl_i.at) begin
        data_q <= left_i;
      end else if (idx_i == ctl_i.at) begin
        data_q <= ctl_i.value;
      end
    end else if (ctl_i.rem) begin
      if (idx_i >= ctl_i.at) begin
        data_q <= right_i;
      end
    end
  end

  // The cell at the removal point keeps its old element for read-out.
  always_ff @(posedge clk_i) begin
    if (ctl_i.rem) begin
      taken_q <= (idx_i == ctl_i.at) ? data_q : '0;
    end
  end

  assign data_o  = data_q;
  assign taken_o = taken_q;

endmodule

[rtl/positional_list_engine.sv]
// ---------------------------------------------------------------------------
// Positional list engine
// Ordered list of handles held in a chain of cells, edited by list commands.
// ---------------------------------------------------------------------------
// The list lives in a row of CAPACITY cells, cell i holding element i. Each
// command transfer on cmd_i gives exactly one transfer on rsp_o with the
// removed element (zero for inserts and failed commands), a status and the
// element count after the command. A command is worked in two steps: in the
// first step every cell decides on its own whether to hold, take the value,
// or take its left or right neighbor, so the whole list shifts at once; in
// the second step the element saved by the cell at the removal point is
// gathered onto the response register. No new command is taken while one is
// in the command stage; with responses drained, the next is taken once the
// last has left it. A command passes through the command stage, the read-out
// stage and the response register. A command that fails (bad position, empty
// list, full list) leaves the list unchanged. Codes 6 and 7 of func do nothing
// and report OK with the unchanged count. The element store needs no clearing
// after reset: only elements below the count are ever read.
module positional_list_engine import pl_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  pl_cmd_if.sink   cmd_i,
  pl_rsp_if.source rsp_o
);

  // Command stage: the accepted command, worked against the cells.
  logic       a_valid_q;
  cmd_t       cmd_q;
  logic [CNT_W-1:0] length_q, length_d;

  // Read-out stage: status and count wait while the removed element is
  // gathered from the cells.
  logic             b_valid_q;
  logic             b_rem_q;
  status_e          b_status_q;
  logic [CNT_W-1:0] b_count_q;

  // Response register.
  logic                rsp_valid_q;
  logic [VALUE_W-1:0]  rsp_value_q;
  status_e             rsp_status_q;
  logic [CNT_W-1:0]    rsp_count_q;

  logic cmd_xfer;
  logic b_take;

  assign b_take      = b_valid_q && (!rsp_valid_q || rsp_o.ready);
  assign cmd_i.ready = !a_valid_q && (!b_valid_q || b_take);
  assign cmd_xfer    = cmd_i.valid && cmd_i.ready;

  // Decode the command against the current count.
  logic             ins_req, rem_req;
  logic [POS_W-1:0] at_w;
  logic [POS_W-1:0] len_w;
  status_e          status_w;
  logic             ins_ok, rem_ok;

  assign len_w = POS_W'(length_q);

  always_comb begin
    ins_req = 1'b0;
    rem_req = 1'b0;
    at_w    = '0;
    case (func_e'(cmd_q.func))
      FN_INS_FRONT: begin
        ins_req = 1'b1;
      end
      FN_INS_BACK: begin
        ins_req = 1'b1;
        at_w    = len_w;
      end
      FN_INS_POS: begin
        ins_req = 1'b1;
        at_w    = cmd_q.pos;
      end
      FN_REM_FRONT: begin
        rem_req = 1'b1;
      end
      FN_REM_BACK: begin
        rem_req = 1'b1;
        at_w    = len_w - POS_W'(1);
      end
      FN_REM_POS: begin
        rem_req = 1'b1;
        at_w    = cmd_q.pos;
      end
      default: begin
        ins_req = 1'b0;
      end
    endcase
  end

  // Position is checked before capacity on inserts; emptiness is checked
  // before position on removes.
  always_comb begin
    status_w = ST_OK;
    if (ins_req) begin
      if (at_w > len_w) begin
        status_w = ST_BADPOS;
      end else if (length_q == CNT_W'(CAPACITY)) begin
        status_w = ST_FULL;
      end
    end else if (rem_req) begin
      if (length_q == '0) begin
        status_w = ST_EMPTY;
      end else if (at_w >= len_w) begin
        status_w = ST_BADPOS;
      end
    end
  end

  assign ins_ok = ins_req && (status_w == ST_OK);
  assign rem_ok = rem_req && (status_w == ST_OK);

  always_comb begin
    length_d = length_q;
    if (a_valid_q && ins_ok) begin
      length_d = length_q + CNT_W'(1);
    end else if (a_valid_q && rem_ok) begin
      length_d = length_q - CNT_W'(1);
    end
  end

  // Cell chain. A successful command is broadcast to every cell.
  cell_ctl_t         ctl;
  logic [ELEM_W-1:0] data_w  [CAPACITY];
  logic [ELEM_W-1:0] taken_w [CAPACITY];

  assign ctl.ins   = a_valid_q && ins_ok;
  assign ctl.rem   = a_valid_q && rem_ok;
  assign ctl.at    = at_w[IDX_W-1:0];
  assign ctl.value = cmd_q.value[ELEM_W-1:0];

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ELEM_W-1:0] left_w, right_w;

    if (i == 0) begin : g_first
      assign left_w = '0;
    end else begin : g_inner_l
      assign left_w = data_w[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign right_w = '0;
    end else begin : g_inner_r
      assign right_w = data_w[i+1];
    end

    pl_cell u_cell (
      .clk_i   (clk_i),
      .idx_i   (IDX_W'(i)),
      .ctl_i   (ctl),
      .left_i  (left_w),
      .right_i (right_w),
      .data_o  (data_w[i]),
      .taken_o (taken_w[i])
    );
  end

  // Only the cell at the removal point holds a nonzero saved element, so
  // an OR over the saved elements yields the removed one.
  logic [ELEM_W-1:0] removed_w;

  always_comb begin
    removed_w = '0;
    for (int unsigned k = 0; k < CAPACITY; k++) begin
      removed_w = removed_w | taken_w[k];
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q   <= 1'b0;
      b_valid_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
      length_q    <= '0;
    end else begin
      a_valid_q <= cmd_xfer;
      length_q  <= length_d;
      if (a_valid_q) begin
        b_valid_q <= 1'b1;
      end else if (b_take) begin
        b_valid_q <= 1'b0;
      end
      if (b_take) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_xfer) begin
      cmd_q.func  <= cmd_i.func;
      cmd_q.pos   <= cmd_i.pos;
      cmd_q.value <= cmd_i.value;
    end
    if (a_valid_q) begin
      b_rem_q    <= rem_ok;
      b_status_q <= status_w;
      b_count_q  <= length_d;
    end
    if (b_take) begin
      rsp_value_q  <= b_rem_q ? VALUE_W'(removed_w) : '0;
      rsp_status_q <= b_status_q;
      rsp_count_q  <= b_count_q;
    end
  end

  assign rsp_o.valid         = rsp_valid_q;
  assign rsp_o.removed_value = rsp_value_q;
  assign rsp_o.status        = rsp_status_q;
  assign rsp_o.count         = rsp_count_q;

endmodule

[rtl/pl_checker.sv]
// ---------------------------------------------------------------------------
// Positional list engine checker
// Port-level assertions on the list engine, attached by bind.
// ---------------------------------------------------------------------------
`include "positional_list_engine_macros.svh"

module pl_checker import pl_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cmd_valid_i,
  input logic                cmd_ready_i,
  input logic                rsp_valid_i,
  input logic                rsp_ready_i,
  input logic [STATUS_W-1:0] rsp_status_i,
  input logic [CNT_W-1:0]    rsp_count_i
);

  logic cmd_xfer;
  logic rsp_xfer;

  assign cmd_xfer = cmd_valid_i && cmd_ready_i;
  assign rsp_xfer = rsp_valid_i && rsp_ready_i;

  // A pending response stays until it is taken.
  `PLE_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i, "response dropped")

  // Commands are worked one at a time, so two transfers never follow directly.
  `PLE_ASSERT(a_cmd_spacing, cmd_xfer |=> !cmd_xfer, "command accepted while busy")

  // An empty-list report always comes with a zero count.
  `PLE_ASSERT(a_empty_count, rsp_xfer && rsp_status_i == ST_EMPTY |-> rsp_count_i == '0,
              "empty status with nonzero count")

  // A full-list report always comes with the count at capacity.
  `PLE_ASSERT(a_full_count,
              rsp_xfer && rsp_status_i == ST_FULL |-> rsp_count_i == CNT_W'(CAPACITY),
              "full status below capacity")

endmodule

bind positional_list_engine pl_checker u_pl_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .cmd_valid_i  (cmd_i.valid),
  .cmd_ready_i  (cmd_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_count_i  (rsp_o.count)
);
